[rtl/elsi_pkg.sv]
// ----------------------------------------------------------------------------
// elsi_pkg: shared constants and types of the error list sorted insert block
// Field widths, operation codes, datapath command codes and the command and
// status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package elsi_pkg;

  // Field and storage sizes
  localparam int IDX_W       = 10;
  localparam int MAX_ENTRIES = 1 << IDX_W;
  localparam int CNT_W       = IDX_W + 1;
  localparam int ERR_W       = 63;
  localparam int OP_W        = 2;

  // Operation codes of an input word
  localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_NORMAL  = 2'd1;
  localparam logic [OP_W-1:0] OP_SPECIAL = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

  // Error store write select
  localparam logic [1:0] EW_NONE  = 2'd0;
  localparam logic [1:0] EW_SPLIT = 2'd1;
  localparam logic [1:0] EW_NEW   = 2'd2;
  localparam logic [1:0] EW_INIT  = 2'd3;

  // Error store read address select
  localparam logic ER_ORDQ = 1'b0;
  localparam logic ER_TIDX = 1'b1;

  // Order store write select (data at address)
  localparam logic [3:0] OW_NONE       = 4'd0;
  localparam logic [3:0] OW_ZERO_AT0   = 4'd1;
  localparam logic [3:0] OW_ONE_AT1    = 4'd2;
  localparam logic [3:0] OW_TAIL_AT1   = 4'd3;
  localparam logic [3:0] OW_TAIL_LAST  = 4'd4;
  localparam logic [3:0] OW_VAL_POS    = 4'd5;
  localparam logic [3:0] OW_VAL_POSM1  = 4'd6;
  localparam logic [3:0] OW_IMAX_POSM1 = 4'd7;
  localparam logic [3:0] OW_TIDX_POS   = 4'd8;

  // Order store read address select
  localparam logic [2:0] OR_MAXPOS = 3'd0;
  localparam logic [2:0] OR_POSM1  = 3'd1;
  localparam logic [2:0] OR_POSM2  = 3'd2;
  localparam logic [2:0] OR_POSP1  = 3'd3;
  localparam logic [2:0] OR_LAST   = 3'd4;
  localparam logic [2:0] OR_LASTM1 = 3'd5;

  // Register update select
  localparam logic [4:0] RG_NONE     = 5'd0;
  localparam logic [4:0] RG_LOAD_IN  = 5'd1;
  localparam logic [4:0] RG_FLAGS    = 5'd2;
  localparam logic [4:0] RG_INIT     = 5'd3;
  localparam logic [4:0] RG_BUMP     = 5'd4;
  localparam logic [4:0] RG_IMAX     = 5'd5;
  localparam logic [4:0] RG_EMAX     = 5'd6;
  localparam logic [4:0] RG_VAL      = 5'd7;
  localparam logic [4:0] RG_POS_DEC  = 5'd8;
  localparam logic [4:0] RG_L2_START = 5'd9;
  localparam logic [4:0] RG_POS_INC  = 5'd10;
  localparam logic [4:0] RG_BOUND    = 5'd11;
  localparam logic [4:0] RG_TIDX     = 5'd12;
  localparam logic [4:0] RG_EMIN     = 5'd13;
  localparam logic [4:0] RG_FINISH   = 5'd14;
  localparam logic [4:0] RG_RES_ORD  = 5'd15;
  localparam logic [4:0] RG_RES_IMAX = 5'd16;
  localparam logic [4:0] RG_OUT      = 5'd17;

  // Controller to datapath
  typedef struct packed {
    logic [1:0] err_wr;
    logic       err_rd;
    logic [3:0] ord_wr;
    logic [2:0] ord_rd;
    logic [4:0] reg_op;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op_init;
    logic op_bad;
    logic special;
    logic cnt_zero;
    logic cnt_full;
    logic short_list;
    logic pos_zero;
    logic pos_gt1;
    logic pos_gt_bound;
    logic next_lt_last;
    logic last_ge_bound;
    logic up_gt;
    logic dn_lt;
    logic ins_ge;
  } sts_t;

endpackage

`default_nettype wire

[rtl/elsi_in_if.sv]
// ----------------------------------------------------------------------------
// elsi_in_if: input channel of the error list sorted insert block
// Valid/ready handshake carrying one operation word.
// ----------------------------------------------------------------------------
`default_nettype none

interface elsi_in_if
  import elsi_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] split_index;
  logic [ERR_W-1:0] split_error;
  logic [ERR_W-1:0] new_error;
  logic [IDX_W-1:0] tail_index;

  modport source (
    output valid, op, split_index, split_error, new_error, tail_index,
    input  ready
  );

  modport sink (
    input  valid, op, split_index, split_error, new_error, tail_index,
    output ready
  );
endinterface

`default_nettype wire

[rtl/elsi_out_if.sv]
// ----------------------------------------------------------------------------
// elsi_out_if: result channel of the error list sorted insert block
// Valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface elsi_out_if
  import elsi_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] max_index;
  logic [IDX_W-1:0] max_position;
  logic [CNT_W-1:0] entry_count;
  logic             full_res;

  modport source (
    output valid, max_index, max_position, entry_count, full_res,
    input  ready
  );

  modport sink (
    input  valid, max_index, max_position, entry_count, full_res,
    output ready
  );
endinterface

`default_nettype wire

[rtl/elsi_ram.sv]
// ----------------------------------------------------------------------------
// elsi_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module elsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire  [$clog2(DEPTH)-1:0]  waddr,
  input  wire  [WIDTH-1:0]          wdata,
  input  wire  [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[rtl/elsi_ctrl.sv]
// ----------------------------------------------------------------------------
// elsi_ctrl: sequencer of the error list sorted insert block
// Walks one operation through its store writes and the three ordering
// passes, issuing one command word to the datapath per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module elsi_ctrl
  import elsi_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  output logic  in_ready,
  input  wire   out_ready,
  output logic  out_valid,
  input  sts_t  sts,
  output cmd_t  cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DEC   = 5'd1;
  localparam logic [4:0] S_INIT  = 5'd2;
  localparam logic [4:0] S_WSPL  = 5'd3;
  localparam logic [4:0] S_WNEW  = 5'd4;
  localparam logic [4:0] S_IMAX  = 5'd5;
  localparam logic [4:0] S_SM0   = 5'd6;
  localparam logic [4:0] S_SM1   = 5'd7;
  localparam logic [4:0] S_EMAX  = 5'd8;
  localparam logic [4:0] S_L1B   = 5'd9;
  localparam logic [4:0] S_L1C   = 5'd10;
  localparam logic [4:0] S_L2A   = 5'd11;
  localparam logic [4:0] S_L2B   = 5'd12;
  localparam logic [4:0] S_L2C   = 5'd13;
  localparam logic [4:0] S_L2E   = 5'd14;
  localparam logic [4:0] S_L3A   = 5'd15;
  localparam logic [4:0] S_L3B   = 5'd16;
  localparam logic [4:0] S_L3C   = 5'd17;
  localparam logic [4:0] S_L3D   = 5'd18;
  localparam logic [4:0] S_L3E   = 5'd19;
  localparam logic [4:0] S_RDRES = 5'd20;
  localparam logic [4:0] S_LDRES = 5'd21;
  localparam logic [4:0] S_FIN   = 5'd22;

  logic [4:0] state_r;
  logic [4:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.reg_op = RG_LOAD_IN;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        cmd.reg_op = RG_FLAGS;
        if (sts.op_init) begin
          state_nxt = S_INIT;
        end else if (sts.op_bad || sts.cnt_zero || sts.cnt_full) begin
          state_nxt = S_RDRES;
        end else begin
          state_nxt = S_WSPL;
        end
      end
      S_INIT: begin
        cmd.err_wr = EW_INIT;
        cmd.ord_wr = OW_ZERO_AT0;
        cmd.reg_op = RG_INIT;
        state_nxt  = S_RDRES;
      end
      S_WSPL: begin
        cmd.err_wr = EW_SPLIT;
        state_nxt  = S_WNEW;
      end
      S_WNEW: begin
        cmd.err_wr = EW_NEW;
        cmd.ord_rd = OR_MAXPOS;
        cmd.reg_op = RG_BUMP;
        state_nxt  = S_IMAX;
      end
      S_IMAX: begin
        // capture the maximum entry and fetch its error
        cmd.reg_op = RG_IMAX;
        cmd.err_rd = ER_ORDQ;
        if (sts.short_list) begin
          state_nxt = S_SM0;
        end else begin
          if (sts.special) begin
            cmd.ord_wr = OW_TAIL_LAST;
          end
          state_nxt = S_EMAX;
        end
      end
      S_SM0: begin
        if (sts.special) begin
          cmd.ord_wr = OW_TAIL_AT1;
          cmd.reg_op = RG_RES_IMAX;
          state_nxt  = S_FIN;
        end else begin
          cmd.ord_wr = OW_ZERO_AT0;
          state_nxt  = S_SM1;
        end
      end
      S_SM1: begin
        cmd.ord_wr = OW_ONE_AT1;
        cmd.reg_op = RG_RES_IMAX;
        state_nxt  = S_FIN;
      end
      S_EMAX: begin
        cmd.reg_op = RG_EMAX;
        cmd.ord_rd = OR_POSM1;
        state_nxt  = sts.pos_zero ? S_L2A : S_L1B;
      end
      // Upward pass: move the maximum past smaller neighbors
      S_L1B: begin
        cmd.reg_op = RG_VAL;
        cmd.err_rd = ER_ORDQ;
        state_nxt  = S_L1C;
      end
      S_L1C: begin
        if (sts.up_gt) begin
          cmd.ord_wr = OW_VAL_POS;
          cmd.ord_rd = OR_POSM2;
          cmd.reg_op = RG_POS_DEC;
          state_nxt  = sts.pos_gt1 ? S_L1B : S_L2A;
        end else begin
          state_nxt = S_L2A;
        end
      end
      // Top-down insertion of the maximum entry
      S_L2A: begin
        cmd.reg_op = RG_L2_START;
        cmd.ord_rd = OR_POSP1;
        state_nxt  = sts.next_lt_last ? S_L2B : S_L2E;
      end
      S_L2B: begin
        cmd.reg_op = RG_VAL;
        cmd.err_rd = ER_ORDQ;
        state_nxt  = S_L2C;
      end
      S_L2C: begin
        if (sts.dn_lt) begin
          cmd.ord_wr = OW_VAL_POSM1;
          cmd.ord_rd = OR_POSP1;
          cmd.reg_op = RG_POS_INC;
          state_nxt  = sts.next_lt_last ? S_L2B : S_L2E;
        end else begin
          state_nxt = S_L2E;
        end
      end
      S_L2E: begin
        cmd.ord_wr = OW_IMAX_POSM1;
        cmd.ord_rd = OR_LAST;
        cmd.reg_op = RG_BOUND;
        state_nxt  = S_L3A;
      end
      // Bottom-up insertion of the tail entry
      S_L3A: begin
        cmd.reg_op = RG_TIDX;
        cmd.err_rd = ER_TIDX;
        state_nxt  = S_L3B;
      end
      S_L3B: begin
        cmd.reg_op = RG_EMIN;
        cmd.ord_rd = OR_LASTM1;
        state_nxt  = sts.last_ge_bound ? S_L3C : S_L3E;
      end
      S_L3C: begin
        cmd.reg_op = RG_VAL;
        cmd.err_rd = ER_ORDQ;
        state_nxt  = S_L3D;
      end
      S_L3D: begin
        if (sts.ins_ge) begin
          cmd.ord_wr = OW_VAL_POS;
          cmd.ord_rd = OR_POSM2;
          cmd.reg_op = RG_POS_DEC;
          state_nxt  = sts.pos_gt_bound ? S_L3C : S_L3E;
        end else begin
          state_nxt = S_L3E;
        end
      end
      S_L3E: begin
        cmd.ord_wr = OW_TIDX_POS;
        cmd.reg_op = RG_FINISH;
        state_nxt  = S_RDRES;
      end
      // Report the entry at the maximum position
      S_RDRES: begin
        cmd.ord_rd = OR_MAXPOS;
        state_nxt  = S_LDRES;
      end
      S_LDRES: begin
        cmd.reg_op = RG_RES_ORD;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.reg_op = RG_OUT;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output word valid: set on load, drop when taken
  always_comb begin
    if (cmd.reg_op == RG_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[rtl/elsi_dp.sv]
// ----------------------------------------------------------------------------
// elsi_dp: datapath of the error list sorted insert block
// Error store, order store, list pointers, comparators and the output
// word register, all driven by the controller's command word.
// ----------------------------------------------------------------------------
`default_nettype none

module elsi_dp
  import elsi_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  wire  [OP_W-1:0]   in_op,
  input  wire  [IDX_W-1:0]  in_split_index,
  input  wire  [ERR_W-1:0]  in_split_error,
  input  wire  [ERR_W-1:0]  in_new_error,
  input  wire  [IDX_W-1:0]  in_tail_index,
  output logic [IDX_W-1:0]  out_max_index,
  output logic [IDX_W-1:0]  out_max_position,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic              out_full_res
);

  // Latched input word
  logic [OP_W-1:0]  op_r;
  logic [IDX_W-1:0] sidx_r;
  logic [ERR_W-1:0] serr_r;
  logic [ERR_W-1:0] nerr_r;
  logic [IDX_W-1:0] tail_r;

  // List state and working registers
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] maxpos_r;
  logic [IDX_W-1:0] last_r;
  logic [IDX_W-1:0] pos_r;
  logic [IDX_W-1:0] nr_r;
  logic [IDX_W-1:0] bound_r;
  logic [IDX_W-1:0] imax_r;
  logic [IDX_W-1:0] tidx_r;
  logic [IDX_W-1:0] val_r;
  logic [IDX_W-1:0] res_r;
  logic [ERR_W-1:0] emax_r;
  logic [ERR_W-1:0] emin_r;
  logic             full_r;

  // Output word register
  logic [IDX_W-1:0] omax_r;
  logic [IDX_W-1:0] opos_r;
  logic [CNT_W-1:0] ocnt_r;
  logic             ofull_r;

  // Memory ports
  logic             err_we;
  logic [IDX_W-1:0] err_waddr;
  logic [ERR_W-1:0] err_wdata;
  logic [IDX_W-1:0] err_raddr;
  logic [ERR_W-1:0] err_q;
  logic             ord_we;
  logic [IDX_W-1:0] ord_waddr;
  logic [IDX_W-1:0] ord_wdata;
  logic [IDX_W-1:0] ord_raddr;
  logic [IDX_W-1:0] ord_q;

  logic [IDX_W-1:0] tidx_nxt;

  elsi_ram #(
    .WIDTH (ERR_W),
    .DEPTH (MAX_ENTRIES)
  ) u_err_ram (
    .clk       (clk),
    .we        (err_we),
    .waddr     (err_waddr),
    .wdata     (err_wdata),
    .raddr     (err_raddr),
    .rd_data_r (err_q)
  );

  elsi_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ord_ram (
    .clk       (clk),
    .we        (ord_we),
    .waddr     (ord_waddr),
    .wdata     (ord_wdata),
    .raddr     (ord_raddr),
    .rd_data_r (ord_q)
  );

  // Tail entry: the caller's index in special mode, else the new entry
  assign tidx_nxt = (op_r == OP_SPECIAL) ? ord_q : last_r;

  // Error store ports
  always_comb begin
    err_we    = 1'b1;
    err_waddr = sidx_r;
    err_wdata = serr_r;
    case (cmd.err_wr)
      EW_SPLIT: begin
        err_waddr = sidx_r;
        err_wdata = serr_r;
      end
      EW_NEW: begin
        err_waddr = count_r[IDX_W-1:0];
        err_wdata = nerr_r;
      end
      EW_INIT: begin
        err_waddr = '0;
        err_wdata = nerr_r;
      end
      default: begin
        err_we = 1'b0;
      end
    endcase
    err_raddr = (cmd.err_rd == ER_TIDX) ? tidx_nxt : ord_q;
  end

  // Order store write port
  always_comb begin
    ord_we    = 1'b1;
    ord_waddr = pos_r;
    ord_wdata = val_r;
    case (cmd.ord_wr)
      OW_ZERO_AT0: begin
        ord_waddr = '0;
        ord_wdata = '0;
      end
      OW_ONE_AT1: begin
        ord_waddr = IDX_W'(1);
        ord_wdata = IDX_W'(1);
      end
      OW_TAIL_AT1: begin
        ord_waddr = IDX_W'(1);
        ord_wdata = tail_r;
      end
      OW_TAIL_LAST: begin
        ord_waddr = last_r;
        ord_wdata = tail_r;
      end
      OW_VAL_POS: begin
        ord_waddr = pos_r;
        ord_wdata = val_r;
      end
      OW_VAL_POSM1: begin
        ord_waddr = pos_r - IDX_W'(1);
        ord_wdata = val_r;
      end
      OW_IMAX_POSM1: begin
        ord_waddr = pos_r - IDX_W'(1);
        ord_wdata = imax_r;
      end
      OW_TIDX_POS: begin
        ord_waddr = pos_r;
        ord_wdata = tidx_r;
      end
      default: begin
        ord_we = 1'b0;
      end
    endcase
  end

  // Order store read port
  always_comb begin
    case (cmd.ord_rd)
      OR_MAXPOS: ord_raddr = maxpos_r;
      OR_POSM1:  ord_raddr = pos_r - IDX_W'(1);
      OR_POSM2:  ord_raddr = pos_r - IDX_W'(2);
      OR_POSP1:  ord_raddr = pos_r + IDX_W'(1);
      OR_LAST:   ord_raddr = last_r;
      OR_LASTM1: ord_raddr = last_r - IDX_W'(1);
      default:   ord_raddr = maxpos_r;
    endcase
  end

  // Status toward the controller
  always_comb begin
    sts.op_init       = (op_r == OP_INIT);
    sts.op_bad        = (op_r == OP_NONE);
    sts.special       = (op_r == OP_SPECIAL);
    sts.cnt_zero      = (count_r == '0);
    sts.cnt_full      = (count_r >= CNT_W'(MAX_ENTRIES));
    sts.short_list    = (last_r < IDX_W'(2));
    sts.pos_zero      = (pos_r == '0);
    sts.pos_gt1       = (pos_r > IDX_W'(1));
    sts.pos_gt_bound  = (pos_r > bound_r);
    sts.next_lt_last  = (({1'b0, pos_r} + CNT_W'(1)) < {1'b0, last_r});
    sts.last_ge_bound = (last_r >= bound_r);
    sts.up_gt         = (emax_r > err_q);
    sts.dn_lt         = (emax_r < err_q);
    sts.ins_ge        = (emin_r >= err_q);
  end

  // List count and maximum position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      maxpos_r <= '0;
    end else begin
      case (cmd.reg_op)
        RG_INIT: begin
          count_r  <= CNT_W'(1);
          maxpos_r <= '0;
        end
        RG_BUMP: begin
          count_r <= count_r + CNT_W'(1);
        end
        RG_FINISH: begin
          maxpos_r <= nr_r;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers and output word
  always_ff @(posedge clk) begin
    case (cmd.reg_op)
      RG_LOAD_IN: begin
        op_r   <= in_op;
        sidx_r <= in_split_index;
        serr_r <= in_split_error;
        nerr_r <= in_new_error;
        tail_r <= in_tail_index;
      end
      RG_FLAGS: begin
        full_r <= ((op_r == OP_NORMAL) || (op_r == OP_SPECIAL))
                  && (count_r >= CNT_W'(MAX_ENTRIES));
      end
      RG_BUMP: begin
        last_r <= count_r[IDX_W-1:0];
      end
      RG_IMAX: begin
        imax_r <= ord_q;
        pos_r  <= maxpos_r;
      end
      RG_EMAX: begin
        emax_r <= err_q;
      end
      RG_VAL: begin
        val_r <= ord_q;
      end
      RG_POS_DEC: begin
        pos_r <= pos_r - IDX_W'(1);
      end
      RG_L2_START: begin
        nr_r  <= pos_r;
        pos_r <= pos_r + IDX_W'(1);
      end
      RG_POS_INC: begin
        pos_r <= pos_r + IDX_W'(1);
      end
      RG_BOUND: begin
        bound_r <= pos_r;
      end
      RG_TIDX: begin
        tidx_r <= tidx_nxt;
      end
      RG_EMIN: begin
        emin_r <= err_q;
        pos_r  <= last_r;
      end
      RG_RES_ORD: begin
        res_r <= ord_q;
      end
      RG_RES_IMAX: begin
        res_r <= imax_r;
      end
      RG_OUT: begin
        omax_r  <= res_r;
        opos_r  <= maxpos_r;
        ocnt_r  <= count_r;
        ofull_r <= full_r;
      end
      default: begin
      end
    endcase
  end

  assign out_max_index    = omax_r;
  assign out_max_position = opos_r;
  assign out_entry_count  = ocnt_r;
  assign out_full_res     = ofull_r;

endmodule

`default_nettype wire

[rtl/error_list_sorted_insert.sv]
// ----------------------------------------------------------------------------
// error_list_sorted_insert: error list keeper with sorted index order
// Stores subinterval errors and keeps an index list in descending error
// order; each step word updates two errors, re-sorts and reports the
// entry at the maximum position.
// ----------------------------------------------------------------------------
//   Channel  Dir  Handshake      Payload
//   in_ch    in   valid/ready    op, split_index, split_error, new_error,
//                                tail_index
//   out_ch   out  valid/ready    max_index, max_position, entry_count, full_res
//
// An init word, an ignored word or a rejected step, and a step on a
// two-entry list take short paths through the sequencer. A
// longer step runs the three passes, each comparison an order store
// read followed by an error store read; the three passes make at most
// about 3 * entry_count comparisons. One word is in work at a time; the
// next can be accepted in the cycle after its result enters the output
// register, and a result still held there by out_ready stalls the sequencer.
// Synchronous active-low reset clears the count and maximum position;
// the stores hold nothing defined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module error_list_sorted_insert
  import elsi_pkg::*;
(
  input wire         clk,
  input wire         rst_n,
  elsi_in_if.sink    in_ch,
  elsi_out_if.source out_ch
);

  cmd_t             cmd;
  sts_t             sts;
  logic             in_ready;
  logic             out_valid;
  logic [IDX_W-1:0] max_index;
  logic [IDX_W-1:0] max_position;
  logic [CNT_W-1:0] entry_count;
  logic             full_res;

  elsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  elsi_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_ch.op),
    .in_split_index   (in_ch.split_index),
    .in_split_error   (in_ch.split_error),
    .in_new_error     (in_ch.new_error),
    .in_tail_index    (in_ch.tail_index),
    .out_max_index    (max_index),
    .out_max_position (max_position),
    .out_entry_count  (entry_count),
    .out_full_res     (full_res)
  );

  // Drive the channel ports
  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.max_index    = max_index;
  assign out_ch.max_position = max_position;
  assign out_ch.entry_count  = entry_count;
  assign out_ch.full_res     = full_res;

endmodule

`default_nettype wire

[verif/elsi_checker.sv]
// ----------------------------------------------------------------------------
// elsi_checker: result checker for the error list sorted insert block
// Watches both channels. Each accepted input word runs through a local
// model of the error store, the sorted order list and the maximum
// position, and the model's answer is queued. Each accepted result word is
// compared field by field with the oldest queued answer.
// ----------------------------------------------------------------------------
module elsi_checker
  import elsi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  elsi_in_if   in_ch,
  elsi_out_if  out_ch,
  output int   fail_count,
  output int   waiting,
  output int   compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHOW_LIMIT = 200;

  typedef struct packed {
    logic [IDX_W-1:0] max_index;
    logic [IDX_W-1:0] max_position;
    logic [CNT_W-1:0] entry_count;
    logic             full_res;
  } result_t;

  // Local copy of the block state
  bit [ERR_W-1:0] err_mem [MAX_ENTRIES];
  bit [IDX_W-1:0] ord_mem [MAX_ENTRIES];
  int             n_entries = 0;
  int             max_pos   = 0;

  result_t        expected_q [$];
  int             fails     = 0;
  int             pending_n = 0;
  int             seen_n    = 0;

  assign fail_count = fails;
  assign waiting    = pending_n;
  assign compared   = seen_n;

  function automatic bit [ERR_W-1:0] err_of_pos(int p);
    return err_mem[ord_mem[p]];
  endfunction

  // Re-sort after a split: lift the head entry, sink it top-down, then
  // insert the tail entry bottom-up. Returns the entry now at the head.
  function automatic bit [IDX_W-1:0] resort(bit special, bit [IDX_W-1:0] tail_in);
    int             last;
    int             nr;
    int             i;
    int             k;
    bit [IDX_W-1:0] imax;
    bit [IDX_W-1:0] tidx;
    bit [ERR_W-1:0] emax;
    bit [ERR_W-1:0] emin;
    last = n_entries - 1;
    nr   = max_pos;
    imax = ord_mem[nr];
    // two entries only: fixed layout, head pointer unchanged
    if (last < 2) begin
      if (special) begin
        ord_mem[1] = tail_in;
      end else begin
        ord_mem[0] = '0;
        ord_mem[1] = IDX_W'(1);
      end
      return imax;
    end
    if (special) ord_mem[last] = tail_in;
    // move the head entry up past strictly smaller errors
    emax = err_mem[imax];
    while (nr > 0 && emax > err_of_pos(nr - 1)) begin
      ord_mem[nr] = ord_mem[nr - 1];
      nr--;
    end
    // sink it down past strictly larger errors
    i = nr + 1;
    while (i < last && emax < err_of_pos(i)) begin
      ord_mem[i - 1] = ord_mem[i];
      i++;
    end
    ord_mem[i - 1] = imax;
    // insert the tail entry from the bottom
    tidx = special ? ord_mem[last] : IDX_W'(last);
    emin = err_mem[tidx];
    k = last - 1;
    while (k > i - 2 && emin >= err_of_pos(k)) begin
      ord_mem[k + 1] = ord_mem[k];
      k--;
    end
    ord_mem[k + 1] = tidx;
    max_pos = nr;
    return ord_mem[nr];
  endfunction

  function automatic result_t predict_result(
    input logic [OP_W-1:0]  op,
    input logic [IDX_W-1:0] sidx,
    input logic [ERR_W-1:0] serr,
    input logic [ERR_W-1:0] nerr,
    input logic [IDX_W-1:0] tidx
  );
    result_t r;
    r.full_res = 1'b0;
    if (op == OP_INIT) begin
      err_mem[0] = nerr;
      ord_mem[0] = '0;
      n_entries  = 1;
      max_pos    = 0;
      r.max_index = '0;
    end else if (op == OP_NONE || n_entries == 0) begin
      r.max_index = ord_mem[max_pos];
    end else if (n_entries >= MAX_ENTRIES) begin
      r.max_index = ord_mem[max_pos];
      r.full_res  = 1'b1;
    end else begin
      err_mem[sidx]      = serr;
      err_mem[n_entries] = nerr;
      n_entries++;
      r.max_index = resort(op == OP_SPECIAL, tidx);
    end
    r.max_position = IDX_W'(max_pos);
    r.entry_count  = CNT_W'(n_entries);
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      fails++;
      if (fails <= SHOW_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compare results first, then queue the answer for a new word
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen_n++;
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= SHOW_LIMIT)
            $display("%0t: result with none expected, actual index %0d pos %0d count %0d full %0d",
                     $time, out_ch.max_index, out_ch.max_position, out_ch.entry_count,
                     out_ch.full_res);
        end else begin
          want = expected_q.pop_front();
          check_field("max_index", want.max_index, out_ch.max_index);
          check_field("max_position", want.max_position, out_ch.max_position);
          check_field("entry_count", want.entry_count, out_ch.entry_count);
          check_field("full_res", want.full_res, out_ch.full_res);
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(predict_result(in_ch.op, in_ch.split_index, in_ch.split_error,
                                            in_ch.new_error, in_ch.tail_index));
      pending_n = expected_q.size();
    end
  end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: top level for the error list sorted insert block
// Drives init, split and ignored words with random gaps on both channels:
// a directed opening, then random lists of mixed sizes. The checker
// beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench
  import elsi_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int             STALL_LIMIT  = 20000;
  localparam int             RANDOM_ITEMS = 540;
  localparam logic [ERR_W-1:0] ERR_MAX    = {ERR_W{1'b1}};

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;
  int   compared;

  elsi_in_if  in_ch ();
  elsi_out_if out_ch ();

  error_list_sorted_insert u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  elsi_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fails),
    .waiting    (pending),
    .compared   (compared)
  );

  // Entries whose error has been written, and the entry count as sent
  bit written [MAX_ENTRIES];
  int n_stored = 0;
  bit in_calm  = 1'b0;
  bit out_calm = 1'b0;
  int n_init = 0, n_normal = 0, n_special = 0, n_noise = 0;
  int stuck = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [ERR_W-1:0] rand_err();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ERR_MAX;
      2, 3:    return ERR_W'($urandom_range(1, 4)) << 40;
      4, 5:    return ERR_W'($urandom_range(0, 1000));
      default: return ERR_W'({$urandom, $urandom});
    endcase
  endfunction

  // Pick an entry with a defined error, favoring the whole store
  function automatic logic [IDX_W-1:0] pick_written();
    int cand;
    repeat (8) begin
      cand = $urandom_range(0, MAX_ENTRIES - 1);
      if (written[cand]) return IDX_W'(cand);
    end
    return IDX_W'($urandom_range(0, n_stored - 1));
  endfunction

  // Output side: hold ready low for random stretches
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!out_calm) hold = pick_gap();
      end
    end
  end

  // Present one word at a falling edge and hold it until accepted
  task automatic send_word(
    input logic [OP_W-1:0]  op,
    input logic [IDX_W-1:0] sidx,
    input logic [ERR_W-1:0] serr,
    input logic [ERR_W-1:0] nerr,
    input logic [IDX_W-1:0] tidx
  );
    int gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.split_index <= sidx;
    in_ch.split_error <= serr;
    in_ch.new_error   <= nerr;
    in_ch.tail_index  <= tidx;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic init_word(input logic [ERR_W-1:0] nerr);
    written[0] = 1'b1;
    n_stored   = 1;
    n_init++;
    send_word(OP_INIT, IDX_W'($urandom), rand_err(), nerr, IDX_W'($urandom));
  endtask

  task automatic noise_word();
    n_noise++;
    send_word(OP_NONE, IDX_W'($urandom), rand_err(), rand_err(), IDX_W'($urandom));
  endtask

  // Split step; a negative tail picks a written entry for special mode
  task automatic step_word(
    input logic [OP_W-1:0]  op,
    input logic [IDX_W-1:0] sidx,
    input logic [ERR_W-1:0] serr,
    input logic [ERR_W-1:0] nerr,
    input int               tail
  );
    logic [IDX_W-1:0] tidx;
    bit               takes;
    takes = (n_stored > 0 && n_stored < MAX_ENTRIES);
    if (takes) begin
      written[sidx]     = 1'b1;
      written[n_stored] = 1'b1;
    end
    if (tail >= 0) tidx = IDX_W'(tail);
    else if (op == OP_SPECIAL) tidx = pick_written();
    else tidx = IDX_W'($urandom);
    if (op == OP_SPECIAL) n_special++;
    else n_normal++;
    send_word(op, sidx, serr, nerr, tidx);
    if (takes) n_stored++;
  endtask

  // Drop valid and hold off until every result is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Stimulus
  initial begin
    int               len;
    int               r;
    int               n_random;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_INIT;
    in_ch.split_index = '0;
    in_ch.split_error = '0;
    in_ch.new_error   = '0;
    in_ch.tail_index  = '0;
    n_random          = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, ties, both small-list layouts, duplicate tails
    init_word(ERR_MAX);
    noise_word();
    step_word(OP_NORMAL, 10'd0, '0, ERR_MAX, -1);
    step_word(OP_NORMAL, 10'd1, ERR_MAX, ERR_MAX, -1);
    step_word(OP_NORMAL, 10'd2, '0, '0, -1);
    step_word(OP_SPECIAL, 10'd1023, ERR_MAX, ERR_W'(5), 1023);
    step_word(OP_NORMAL, 10'd3, ERR_W'(1), ERR_MAX, -1);
    noise_word();
    init_word('0);
    step_word(OP_SPECIAL, 10'd1, ERR_W'(7), ERR_W'(3), 1);
    step_word(OP_SPECIAL, 10'd0, ERR_MAX, '0, 0);
    step_word(OP_NORMAL, 10'd512, ERR_MAX, ERR_MAX, -1);
    step_word(OP_SPECIAL, 10'd2, '0, ERR_MAX, 512);
    step_word(OP_NORMAL, 10'd1, ERR_W'(2), ERR_W'(2), -1);
    step_word(OP_NORMAL, 10'd4, ERR_MAX, '0, -1);
    drain_results();

    // random lists, mostly short, a few long
    while (n_random < RANDOM_ITEMS) begin
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                             : $urandom_range(3, 40);
      in_calm  = ($urandom_range(0, 4) == 0);
      out_calm = ($urandom_range(0, 4) == 0);
      init_word(rand_err());
      n_random++;
      for (int j = 0; j < len && n_random < RANDOM_ITEMS; j++) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          noise_word();
        end else if (r < 7) begin
          init_word(rand_err());
          n_random++;
        end else begin
          step_word((r < 60) ? OP_NORMAL : OP_SPECIAL,
                    ($urandom_range(0, 1) == 0) ? pick_written() : IDX_W'($urandom),
                    rand_err(), rand_err(), -1);
          n_random++;
        end
      end
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    // wait out the last results
    drain_results();
    repeat (30) @(posedge clk);
    $display("covered %0d init words, %0d normal and %0d special steps, %0d ignored words",
             n_init, n_normal, n_special, n_noise);
    $display("%0d result words checked", compared);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck == STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule

[sim.f]
rtl/elsi_pkg.sv
rtl/elsi_in_if.sv
rtl/elsi_out_if.sv
rtl/elsi_ram.sv
rtl/elsi_ctrl.sv
rtl/elsi_dp.sv
rtl/error_list_sorted_insert.sv
verif/elsi_checker.sv
verif/testbench.sv
